// ===== sv/latency_stats_histogram_top_assert.svh =====
// Assertion macros for the latency statistics block.
// Each macro checks on the rising edge of i_clk and is off while i_rst_n is low.
`ifndef LATENCY_STATS_HISTOGRAM_TOP_ASSERT_SVH
`define LATENCY_STATS_HISTOGRAM_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property.
`define LSH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check that a condition never holds.
`define LSH_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define LSH_ASSERT(label, prop, msg)
`define LSH_NEVER(label, cond, msg)
`endif
`endif

// ===== sv/lsh_pkg.sv =====
package lsh_pkg;

    // histogram geometry
    localparam int CAP_BUCKET      = 6000;
    localparam int BUCKET_WIDTH_MS = 10;
    localparam int IDX_W           = $clog2(CAP_BUCKET + 1);
    localparam int CAP_MS          = CAP_BUCKET * BUCKET_WIDTH_MS;
    localparam int KEY_W           = $clog2(CAP_MS + 1);

    // counters and raw widths
    localparam int CNT_W   = 32;
    localparam int REQ_W   = 31;
    localparam int TIME_W  = 48;
    localparam int VALUE_W = 48;

    // divide by bucket width through a reciprocal, exact for inputs below 2**MS_W
    localparam int MS_W      = $clog2(CAP_MS + BUCKET_WIDTH_MS);
    localparam int REC_SHIFT = MS_W + $clog2(BUCKET_WIDTH_MS);
    localparam longint unsigned RECIP =
        ((64'd1 << REC_SHIFT) + 64'(BUCKET_WIDTH_MS) - 64'd1) / 64'(BUCKET_WIDTH_MS);
    localparam int PROD_W    = MS_W + REC_SHIFT + 1;

    // percentile compare: 100 * running_sum >= 95 * sample_total
    localparam int PCT_NUM   = 95;
    localparam int PCT_SCALE = 100;
    localparam int SCALE_W   = CNT_W + $clog2(PCT_SCALE + 1);
    localparam int SUM_W     = SCALE_W + IDX_W + 1;

    // commands
    localparam logic [1:0] CMD_CONN   = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    // report words
    localparam int NUM_STATS = 11;
    localparam int STAT_W    = 4;

    typedef enum logic [STAT_W-1:0] {
        STAT_SAMPLES     = 4'd0,
        STAT_PAIRED      = 4'd1,
        STAT_VALID       = 4'd2,
        STAT_UNAVAILABLE = 4'd3,
        STAT_LOWBIAS     = 4'd4,
        STAT_IMBALANCE   = 4'd5,
        STAT_CONNECTS    = 4'd6,
        STAT_DISCONNECTS = 4'd7,
        STAT_MAXREQ      = 4'd8,
        STAT_P95         = 4'd9,
        STAT_MAXGAP      = 4'd10
    } t_stat_id;

    // top to histogram
    typedef struct packed {
        logic             upd;
        logic             walk;
        logic [IDX_W-1:0] idx;
        logic [SCALE_W-1:0] need;
    } t_hist_req;

    // histogram to top
    typedef struct packed {
        logic             can_take;
        logic             done;
        logic [KEY_W-1:0] p95;
    } t_hist_stat;

    // saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

// ===== sv/lsh_histogram.sv =====
module lsh_histogram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lsh_pkg::t_hist_req  i_req,
    output lsh_pkg::t_hist_stat o_stat
);
    import lsh_pkg::*;

    typedef enum logic [5:0] {
        H_CLEAR = 6'b000001,
        H_IDLE  = 6'b000010,
        H_RD    = 6'b000100,
        H_WR    = 6'b001000,
        H_WALK  = 6'b010000,
        H_DRAIN = 6'b100000
    } t_hstate;

    t_hstate            r_state;
    logic [IDX_W-1:0]   r_addr;
    logic [CNT_W-1:0]   r_mem [0:CAP_BUCKET];
    logic [CNT_W-1:0]   r_rdata;
    logic               w_we;
    logic [CNT_W-1:0]   w_wdata;
    logic               w_take;
    logic               w_walk_start;

    // walk pipeline
    logic               r_v1, r_last1;
    logic               r_v2, r_last2;
    logic               r_nz2;
    logic [SCALE_W-1:0] r_scaled;
    logic [SCALE_W-1:0] r_need;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;
    logic               r_found;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_key_cnt;
    logic               r_done;

    assign w_take       = (r_state == H_IDLE) || (r_state == H_WR);
    assign w_walk_start = w_take && !i_req.upd && i_req.walk;
    assign w_we         = (r_state == H_CLEAR) || (r_state == H_WR);
    assign w_wdata      = (r_state == H_CLEAR) ? '0 : sat_inc(r_rdata);
    assign n_sum        = r_sum + SUM_W'(r_scaled);

    // bucket memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr] <= w_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    // sequencer: clearing pass, read-modify-write, walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_CLEAR;
            r_addr  <= '0;
            r_v1    <= 1'b0;
            r_last1 <= 1'b0;
            r_v2    <= 1'b0;
            r_last2 <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done  <= 1'b0;
            r_v1    <= 1'b0;
            r_last1 <= 1'b0;
            r_v2    <= r_v1;
            r_last2 <= r_last1;
            unique case (r_state)
                H_CLEAR: begin
                    if (r_addr == IDX_W'(CAP_BUCKET)) begin
                        r_addr  <= '0;
                        r_state <= H_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                H_IDLE, H_WR: begin
                    if (i_req.upd) begin
                        r_addr  <= i_req.idx;
                        r_state <= H_RD;
                    end else if (i_req.walk) begin
                        r_addr  <= '0;
                        r_state <= H_WALK;
                    end else begin
                        r_state <= H_IDLE;
                    end
                end
                H_RD: begin
                    r_state <= H_WR;
                end
                H_WALK: begin
                    r_v1    <= 1'b1;
                    r_last1 <= (r_addr == IDX_W'(CAP_BUCKET));
                    if (r_addr == IDX_W'(CAP_BUCKET)) begin
                        r_state <= H_DRAIN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                H_DRAIN: begin
                    if (r_v2 && r_last2) begin
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end
                end
                default: begin
                    r_state <= H_CLEAR;
                end
            endcase
        end
    end

    // walk datapath: scale, accumulate, latch first bucket that reaches the threshold
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_scaled <= SCALE_W'(r_rdata) * SCALE_W'(PCT_SCALE);
            r_nz2    <= (r_rdata != '0);
        end
        if (w_walk_start) begin
            r_need    <= i_req.need;
            r_sum     <= '0;
            r_found   <= 1'b0;
            r_key     <= '0;
            r_key_cnt <= '0;
        end else if (r_v2) begin
            if (r_nz2) begin
                if (!r_found) begin
                    r_key <= r_key_cnt;
                end
                if (n_sum >= SUM_W'(r_need)) begin
                    r_found <= 1'b1;
                end
                r_sum <= n_sum;
            end
            r_key_cnt <= KEY_W'(r_key_cnt + KEY_W'(BUCKET_WIDTH_MS));
        end
    end

    assign o_stat.can_take = w_take;
    assign o_stat.done     = r_done;
    assign o_stat.p95      = r_key;

endmodule

// ===== sv/latency_stats_histogram_top.sv =====
// Latency statistics collector with a 95th-percentile histogram.
// Input channel (i_in_valid / o_in_ready) takes one command word: a connection
// event, a telemetry sample or a report request. Output channel
// (o_out_valid / i_out_ready) delivers report words of stat_id, stat_value, last.
// After reset the block runs a clearing pass over the 6001 histogram buckets,
// one bucket a cycle; o_in_ready stays low until the pass is done.
// For a sample the bucket
// is read from the bucket memory and written back incremented, and the next
// word is accepted in the write-back cycle.
// A report walks all 6001 buckets through the single memory read port, one
// bucket a cycle, then drains the walk pipeline before the first report word
// shows; the eleven words follow one per cycle, while the receiver is ready,
// from an output register. While words are pending no input is taken, and a
// stalled receiver simply holds the current word until it is taken.
`include "latency_stats_histogram_top_assert.svh"
module latency_stats_histogram_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic                          i_online,
    input  logic                          i_success,
    input  logic                          i_formal_force_valid,
    input  logic                          i_low_load_bias_invalid,
    input  logic                          i_imbalance_finite,
    input  logic [lsh_pkg::TIME_W-1:0]    i_observed_ms,
    input  logic signed [31:0]            i_request_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lsh_pkg::STAT_W-1:0]    o_stat_id,
    output logic [lsh_pkg::VALUE_W-1:0]   o_stat_value,
    output logic                          o_last
);
    import lsh_pkg::*;

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_WALK = 3'b010,
        T_EMIT = 3'b100
    } t_state;

    t_state              r_state;
    logic                w_acc;
    t_hist_req           hist_req;
    t_hist_stat          hist_st;

    // statistics state
    logic                r_link_online;
    logic [CNT_W-1:0]    r_sample_total;
    logic [CNT_W-1:0]    r_paired_total;
    logic [CNT_W-1:0]    r_valid_total;
    logic [CNT_W-1:0]    r_unavail_total;
    logic [CNT_W-1:0]    r_low_bias_total;
    logic [CNT_W-1:0]    r_imbalance_total;
    logic [CNT_W-1:0]    r_connect_total;
    logic [CNT_W-1:0]    r_disconnect_total;
    logic                r_have_prev;
    logic [TIME_W-1:0]   r_prev_obs;
    logic [TIME_W-1:0]   r_max_gap;
    logic [REQ_W-1:0]    r_max_req;

    // report output
    logic [STAT_W-1:0]   r_emit_cnt;
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_out_id;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_last;
    logic [VALUE_W-1:0]  w_stat_value;

    // sample decode
    logic [REQ_W-1:0]    w_req_ms;
    logic                w_over;
    logic [MS_W-1:0]     w_ms;
    logic [PROD_W-1:0]   w_prod;
    logic [IDX_W-1:0]    w_idx;
    logic [TIME_W-1:0]   w_gap;
    logic                w_valid_smp;

    assign o_in_ready = (r_state == T_IDLE) && hist_st.can_take;
    assign w_acc      = i_in_valid && o_in_ready;

    // bucket index: ceil(latency / width), capped
    assign w_req_ms = i_request_ms[31] ? '0 : i_request_ms[REQ_W-1:0];
    assign w_over   = (w_req_ms > REQ_W'(CAP_MS));
    assign w_ms     = MS_W'(w_req_ms) + MS_W'(BUCKET_WIDTH_MS - 1);
    assign w_prod   = PROD_W'(w_ms) * PROD_W'(RECIP);
    assign w_idx    = w_over ? IDX_W'(CAP_BUCKET) : IDX_W'(w_prod >> REC_SHIFT);

    assign w_gap       = i_observed_ms - r_prev_obs;
    assign w_valid_smp = i_success && i_formal_force_valid;

    // histogram requests
    assign hist_req.upd  = w_acc && (i_command == CMD_SAMPLE);
    assign hist_req.walk = w_acc && (i_command == CMD_REPORT);
    assign hist_req.idx  = w_idx;
    assign hist_req.need = SCALE_W'(r_sample_total) * SCALE_W'(PCT_NUM);

    lsh_histogram u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hist_req),
        .o_stat  (hist_st)
    );

    // counters and extremes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_online      <= 1'b0;
            r_sample_total     <= '0;
            r_paired_total     <= '0;
            r_valid_total      <= '0;
            r_unavail_total    <= '0;
            r_low_bias_total   <= '0;
            r_imbalance_total  <= '0;
            r_connect_total    <= '0;
            r_disconnect_total <= '0;
            r_have_prev        <= 1'b0;
            r_prev_obs         <= '0;
            r_max_gap          <= '0;
            r_max_req          <= '0;
        end else if (w_acc) begin
            unique case (i_command)
                CMD_CONN: begin
                    if (i_online && !r_link_online) begin
                        r_connect_total <= sat_inc(r_connect_total);
                    end
                    if (!i_online && r_link_online) begin
                        r_disconnect_total <= sat_inc(r_disconnect_total);
                    end
                    r_link_online <= i_online;
                end
                CMD_SAMPLE: begin
                    r_sample_total <= sat_inc(r_sample_total);
                    if (i_success) begin
                        r_paired_total <= sat_inc(r_paired_total);
                    end
                    if (w_valid_smp) begin
                        r_valid_total <= sat_inc(r_valid_total);
                    end else begin
                        r_unavail_total <= sat_inc(r_unavail_total);
                    end
                    if (w_valid_smp && i_low_load_bias_invalid) begin
                        r_low_bias_total <= sat_inc(r_low_bias_total);
                    end
                    if (w_valid_smp && !i_low_load_bias_invalid && i_imbalance_finite) begin
                        r_imbalance_total <= sat_inc(r_imbalance_total);
                    end
                    if (r_have_prev && (i_observed_ms > r_prev_obs) && (w_gap > r_max_gap)) begin
                        r_max_gap <= w_gap;
                    end
                    r_have_prev <= 1'b1;
                    r_prev_obs  <= i_observed_ms;
                    if (w_req_ms > r_max_req) begin
                        r_max_req <= w_req_ms;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // report word select
    always_comb begin
        unique case (t_stat_id'(r_emit_cnt))
            STAT_SAMPLES:     w_stat_value = VALUE_W'(r_sample_total);
            STAT_PAIRED:      w_stat_value = VALUE_W'(r_paired_total);
            STAT_VALID:       w_stat_value = VALUE_W'(r_valid_total);
            STAT_UNAVAILABLE: w_stat_value = VALUE_W'(r_unavail_total);
            STAT_LOWBIAS:     w_stat_value = VALUE_W'(r_low_bias_total);
            STAT_IMBALANCE:   w_stat_value = VALUE_W'(r_imbalance_total);
            STAT_CONNECTS:    w_stat_value = VALUE_W'(r_connect_total);
            STAT_DISCONNECTS: w_stat_value = VALUE_W'(r_disconnect_total);
            STAT_MAXREQ:      w_stat_value = VALUE_W'(r_max_req);
            STAT_P95:         w_stat_value = VALUE_W'(hist_st.p95);
            STAT_MAXGAP:      w_stat_value = VALUE_W'(r_max_gap);
            default:          w_stat_value = '0;
        endcase
    end

    // control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_emit_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_out_id    <= '0;
            r_out_value <= '0;
            r_out_last  <= 1'b0;
        end else begin
            unique case (r_state)
                T_IDLE: begin
                    if (hist_req.walk) begin
                        r_state <= T_WALK;
                    end
                end
                T_WALK: begin
                    if (hist_st.done) begin
                        r_emit_cnt <= '0;
                        r_state    <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        if (r_emit_cnt != STAT_W'(NUM_STATS)) begin
                            r_out_valid <= 1'b1;
                            r_out_id    <= r_emit_cnt;
                            r_out_value <= w_stat_value;
                            r_out_last  <= (r_emit_cnt == STAT_W'(NUM_STATS - 1));
                            r_emit_cnt  <= r_emit_cnt + 1'b1;
                        end else begin
                            r_out_valid <= 1'b0;
                            r_state     <= T_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_stat_id    = r_out_id;
    assign o_stat_value = r_out_value;
    assign o_last       = r_out_last;

    // checks
    `LSH_NEVER(a_no_input_while_emit, o_out_valid && o_in_ready, "input taken during report")
    `LSH_ASSERT(a_last_is_maxgap, (o_out_valid && o_last) |-> (o_stat_id == STAT_MAXGAP), "last flag on wrong word")
    `LSH_ASSERT(a_report_walks, hist_req.walk |=> (r_state == T_WALK), "report did not start walk")
    `LSH_ASSERT(a_done_in_walk, hist_st.done |-> (r_state == T_WALK), "walk done outside walk")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import lsh_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;   // unused command, dropped by the block
    localparam int IDLE_PCT           = 37;
    localparam int RANDOM_WORDS       = 140;
    localparam int MAX_RANDOM_REPORTS = 12;
    localparam int DRAIN_LIMIT        = 50000;
    localparam int TAIL_CYCLES        = 20;
    localparam int MAX_PRINTED        = 60;
    localparam longint LIMIT_NS       = 20_000_000;  // hard stop, at a 20 ns clock period

    // one command word on the input channel
    typedef struct packed {
        logic [1:0]        cmd;
        logic              online;
        logic              success;
        logic              ffv;
        logic              lbi;
        logic              finite;
        logic [TIME_W-1:0] obs;
        logic [31:0]       req;
        logic              typed_zero;  // report with an all-zero answer typed in
    } cmd_word_t;

    // one report word on the output channel
    typedef struct packed {
        logic [STAT_W-1:0]  id;
        logic [VALUE_W-1:0] value;
        logic               last;
    } stat_word_t;

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_command = CMD_CONN;
    logic                      i_online = 1'b0;
    logic                      i_success = 1'b0;
    logic                      i_formal_force_valid = 1'b0;
    logic                      i_low_load_bias_invalid = 1'b0;
    logic                      i_imbalance_finite = 1'b0;
    logic [TIME_W-1:0]         i_observed_ms = '0;
    logic signed [31:0]        i_request_ms = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [STAT_W-1:0]         o_stat_id;
    logic [VALUE_W-1:0]        o_stat_value;
    logic                      o_last;

    latency_stats_histogram_top dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_command               (i_command),
        .i_online                (i_online),
        .i_success               (i_success),
        .i_formal_force_valid    (i_formal_force_valid),
        .i_low_load_bias_invalid (i_low_load_bias_invalid),
        .i_imbalance_finite      (i_imbalance_finite),
        .i_observed_ms           (i_observed_ms),
        .i_request_ms            (i_request_ms),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_stat_id               (o_stat_id),
        .o_stat_value            (o_stat_value),
        .o_last                  (o_last)
    );

    // predicted statistics state
    logic              link_up;
    logic [CNT_W-1:0]  stat_cnt [0:7];     // indexed by stat id 0..7
    logic              seen_sample;
    logic [TIME_W-1:0] last_obs;
    logic [TIME_W-1:0] widest_gap;
    logic [REQ_W-1:0]  peak_req;
    logic [CNT_W-1:0]  hist_cnt [0:CAP_BUCKET];

    stat_word_t pending_stats[$];   // report words still to come, oldest first
    cmd_word_t  directed_rows[$];
    int         err_count = 0;
    bit         steady = 1'b0;      // no idling on either side while set
    logic [TIME_W-1:0] gen_time = '0;
    int         rand_reports = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic logic [CNT_W-1:0] step_count(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    task automatic clear_stats();
        int i;
        link_up     = 1'b0;
        seen_sample = 1'b0;
        last_obs    = '0;
        widest_gap  = '0;
        peak_req    = '0;
        for (i = 0; i < 8; i++)
            stat_cnt[i] = '0;
        for (i = 0; i <= CAP_BUCKET; i++)
            hist_cnt[i] = '0;
    endtask

    // ascending walk: first bucket whose running sum reaches 95% of samples
    function automatic logic [VALUE_W-1:0] p95_key();
        longint unsigned need;
        longint unsigned total;
        logic [VALUE_W-1:0] key;
        bit hit;
        int i;
        need  = (64'(stat_cnt[STAT_SAMPLES]) * PCT_NUM + PCT_SCALE - 1) / PCT_SCALE;
        total = 0;
        key   = '0;
        hit   = 1'b0;
        for (i = 0; i <= CAP_BUCKET && !hit; i++) begin
            if (hist_cnt[i] != 0) begin
                total = total + hist_cnt[i];
                key   = VALUE_W'(i * BUCKET_WIDTH_MS);
                hit   = (total >= need);
            end
        end
        return key;
    endfunction

    function automatic logic [VALUE_W-1:0] stat_value_of(input int s);
        if (s < 8)
            return VALUE_W'(stat_cnt[s]);
        else if (s == STAT_MAXREQ)
            return VALUE_W'(peak_req);
        else if (s == STAT_P95)
            return p95_key();
        else
            return widest_gap;
    endfunction

    // update predicted state for one accepted word, queue any report words
    task automatic absorb_word(input cmd_word_t w);
        logic [REQ_W-1:0] req;
        longint unsigned  idx;
        stat_word_t       sw;
        int               s;
        case (w.cmd)
            CMD_CONN: begin
                if (w.online && !link_up)
                    stat_cnt[STAT_CONNECTS] = step_count(stat_cnt[STAT_CONNECTS]);
                if (!w.online && link_up)
                    stat_cnt[STAT_DISCONNECTS] = step_count(stat_cnt[STAT_DISCONNECTS]);
                link_up = w.online;
            end
            CMD_SAMPLE: begin
                stat_cnt[STAT_SAMPLES] = step_count(stat_cnt[STAT_SAMPLES]);
                if (w.success)
                    stat_cnt[STAT_PAIRED] = step_count(stat_cnt[STAT_PAIRED]);
                if (w.success && w.ffv)
                    stat_cnt[STAT_VALID] = step_count(stat_cnt[STAT_VALID]);
                else
                    stat_cnt[STAT_UNAVAILABLE] = step_count(stat_cnt[STAT_UNAVAILABLE]);
                if (w.success && w.ffv && w.lbi)
                    stat_cnt[STAT_LOWBIAS] = step_count(stat_cnt[STAT_LOWBIAS]);
                if (w.success && w.ffv && !w.lbi && w.finite)
                    stat_cnt[STAT_IMBALANCE] = step_count(stat_cnt[STAT_IMBALANCE]);
                // gap only counts forward in time, and only after a first sample
                if (seen_sample && w.obs > last_obs && (w.obs - last_obs) > widest_gap)
                    widest_gap = w.obs - last_obs;
                seen_sample = 1'b1;
                last_obs    = w.obs;
                // negative latency clamps to zero
                req = w.req[31] ? '0 : w.req[REQ_W-1:0];
                if (req > peak_req)
                    peak_req = req;
                idx = (64'(req) + BUCKET_WIDTH_MS - 1) / BUCKET_WIDTH_MS;
                if (idx > CAP_BUCKET)
                    idx = CAP_BUCKET;
                hist_cnt[idx] = step_count(hist_cnt[idx]);
            end
            CMD_REPORT: begin
                for (s = 0; s < NUM_STATS; s++) begin
                    sw.id    = STAT_W'(s);
                    sw.value = w.typed_zero ? '0 : stat_value_of(s);
                    sw.last  = (s == NUM_STATS - 1);
                    pending_stats.push_back(sw);
                end
            end
            default: ;
        endcase
    endtask

    // push one word, idling at random before it, wait for the handshake
    task automatic send_word(input cmd_word_t w);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_command               <= w.cmd;
        i_online                <= w.online;
        i_success               <= w.success;
        i_formal_force_valid    <= w.ffv;
        i_low_load_bias_invalid <= w.lbi;
        i_imbalance_finite      <= w.finite;
        i_observed_ms           <= w.obs;
        i_request_ms            <= w.req;
        i_in_valid              <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        absorb_word(w);
    endtask

    task automatic add_row(input logic [1:0] cmd, input logic online, input logic success,
                           input logic ffv, input logic lbi, input logic finite,
                           input logic [TIME_W-1:0] obs, input logic [31:0] req,
                           input logic typed_zero);
        cmd_word_t w;
        w = '{cmd, online, success, ffv, lbi, finite, obs, req, typed_zero};
        directed_rows.push_back(w);
    endtask

    // random word: mostly samples with forward-moving times
    task automatic make_random(output cmd_word_t w);
        int pick;
        w = '0;
        w.online  = 1'($urandom_range(1));
        w.success = 1'($urandom_range(1));
        w.ffv     = 1'($urandom_range(1));
        w.lbi     = 1'($urandom_range(1));
        w.finite  = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 15)
            w.cmd = CMD_CONN;
        else if (pick < 21 && rand_reports < MAX_RANDOM_REPORTS)
            w.cmd = CMD_REPORT;
        else if (pick >= 21 && pick < 25)
            w.cmd = CMD_SPARE;
        else
            w.cmd = CMD_SAMPLE;

        pick = $urandom_range(99);
        if (pick < 70)
            gen_time = gen_time + $urandom_range(5000);
        else if (pick < 85)
            gen_time = gen_time - $urandom_range(3000);
        else
            gen_time = TIME_W'({$urandom, $urandom});
        w.obs = gen_time;

        pick = $urandom_range(99);
        if (pick < 50)
            w.req = $urandom_range(700);
        else if (pick < 70)
            w.req = $urandom_range(60010);
        else if (pick < 80)
            w.req = $urandom_range(59950, 60020);
        else if (pick < 90)
            w.req = 32'h8000_0000 | $urandom;
        else
            w.req = $urandom;
    endtask

    // output side: random back-pressure
    always @(posedge i_clk)
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // check each taken report word against the oldest expectation
    always @(posedge i_clk) begin
        stat_word_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_stats.size() == 0) begin
                report_error($sformatf("unexpected word id=%0d value=%0d last=%0d",
                                       o_stat_id, o_stat_value, o_last));
            end else begin
                want = pending_stats.pop_front();
                if (o_stat_id !== want.id)
                    report_error($sformatf("stat_id got %0d want %0d", o_stat_id, want.id));
                if (o_stat_value !== want.value)
                    report_error($sformatf("stat_value id=%0d got %0d want %0d",
                                           want.id, o_stat_value, want.value));
                if (o_last !== want.last)
                    report_error($sformatf("last id=%0d got %0d want %0d",
                                           want.id, o_last, want.last));
            end
        end
    end

    // main sequence
    initial begin : stimulus
        cmd_word_t w;
        int k;
        int done;
        int guard;
        clear_stats();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: empty histogram, edges, clamping, bucket edges, cap, extremes
        add_row(CMD_REPORT, 0, 0, 0, 0, 0, '0, 32'd0, 1);             // all zero after reset
        add_row(CMD_SPARE,  1, 1, 1, 1, 1, '1, 32'hFFFF_FFFF, 0);     // ignored command
        add_row(CMD_CONN,   1, 0, 0, 0, 0, '0, 32'd0, 0);
        add_row(CMD_CONN,   1, 0, 0, 0, 0, '0, 32'd0, 0);             // no edge
        add_row(CMD_CONN,   0, 0, 0, 0, 0, '0, 32'd0, 0);
        add_row(CMD_CONN,   0, 0, 0, 0, 0, '0, 32'd0, 0);             // no edge
        add_row(CMD_CONN,   1, 0, 0, 0, 0, '0, 32'd0, 0);
        add_row(CMD_SAMPLE, 0, 1, 1, 0, 1, 48'd1000, 32'd0, 0);       // first sample, no gap
        add_row(CMD_SAMPLE, 0, 1, 1, 1, 1, 48'd1500, 32'hFFFF_FFFF, 0); // -1 clamps
        add_row(CMD_SAMPLE, 0, 1, 0, 0, 1, 48'd1500, 32'd10, 0);      // same time, exact edge
        add_row(CMD_SAMPLE, 0, 0, 1, 1, 0, 48'd700, 32'd11, 0);       // time goes back
        add_row(CMD_SAMPLE, 0, 1, 1, 0, 0, 48'd1234, 32'd59990, 0);   // last bucket below cap
        add_row(CMD_SAMPLE, 0, 0, 0, 0, 1, 48'd1300, 32'd59991, 0);   // capped bucket
        add_row(CMD_REPORT, 0, 0, 0, 0, 0, '0, 32'd0, 0);
        add_row(CMD_SAMPLE, 1, 1, 1, 0, 1, '1, 32'h7FFF_FFFF, 0);     // largest time and latency
        add_row(CMD_SAMPLE, 1, 0, 0, 1, 1, '0, 32'h8000_0000, 0);     // most negative latency
        add_row(CMD_SPARE,  0, 0, 0, 0, 0, '0, 32'd0, 0);
        add_row(CMD_CONN,   0, 0, 0, 0, 0, '0, 32'd0, 0);
        add_row(CMD_REPORT, 0, 0, 0, 0, 0, '0, 32'd0, 0);
        add_row(CMD_SAMPLE, 0, 1, 1, 1, 0, 48'd5, 32'd9, 0);
        add_row(CMD_SAMPLE, 0, 1, 1, 0, 1, 48'd5, 32'd1, 0);
        add_row(CMD_REPORT, 0, 0, 0, 0, 0, '0, 32'd0, 0);
        for (k = 0; k < directed_rows.size(); k++)
            send_word(directed_rows[k]);

        // random part
        done = 0;
        while (done < RANDOM_WORDS) begin
            steady = (done >= 100 && done < 130);
            make_random(w);
            if (done == 80 || done == 115)
                w.cmd = CMD_REPORT;
            if (w.cmd == CMD_REPORT)
                rand_reports++;
            send_word(w);
            // hold the sender off until the report has fully drained
            if (done == 80) begin
                i_in_valid <= 1'b0;
                while (pending_stats.size() != 0)
                    @(posedge i_clk);
            end
            if (w.cmd != CMD_SPARE)
                done++;
        end
        steady = 1'b0;

        // closing report on the final state
        w = '0;
        w.cmd = CMD_REPORT;
        send_word(w);
        i_in_valid <= 1'b0;

        guard = 0;
        while (pending_stats.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_stats.size() != 0)
            report_error($sformatf("%0d report words never arrived", pending_stats.size()));

        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
